@@ rtl/core/block_cipher_cmac_macros.svh @@
// Assertion macros used by the checker module.
`ifndef BLOCK_CIPHER_CMAC_MACROS_SVH
`define BLOCK_CIPHER_CMAC_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CMAC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cmac_pkg.sv @@
package cmac_pkg;

    localparam int CIPHER_ROUNDS = 10;
    localparam int RK_DEPTH      = CIPHER_ROUNDS;
    localparam int RK_AW         = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY0     = 3'd0;
    localparam logic [2:0] REG_KEY1     = 3'd1;
    localparam logic [2:0] REG_KEY2     = 3'd2;
    localparam logic [2:0] REG_KEY3     = 3'd3;
    localparam logic [2:0] REG_MAC_BYTES = 3'd4;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  byte_count;
        logic        last_block;
    } in_item_t;

    typedef struct packed {
        logic [63:0] mac_high;
        logic [63:0] mac_low;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] data;
    } cfg_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
        8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
        8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
        8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
        8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
        8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
        8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
        8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
        8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
        8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
        8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
        8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
        8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
        8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
        8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
        8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
    };

    localparam logic [7:0] LIN_COEF [16] = '{
        8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
        8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
    };

    // Multiply in GF(2^8) modulo x^8+x^7+x^6+x+1.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = '0;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ x;
            x = x[7] ? ((x << 1) ^ 8'hC3) : (x << 1);
        end
        return r;
    endfunction

    // One step of the linear feedback: new byte 0, others shift right.
    function automatic logic [127:0] r_step(input logic [127:0] s);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 16; i++)
            acc = acc ^ gf_mul(s[127 - 8*i -: 8], LIN_COEF[i]);
        return {acc, s[127:8]};
    endfunction

    // Substitution of all sixteen bytes.
    function automatic logic [127:0] sub_bytes(input logic [127:0] s);
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            r[8*i +: 8] = SBOX[s[8*i +: 8]];
        return r;
    endfunction

    // Doubling in GF(2^128) with the constant 0x87.
    function automatic logic [127:0] dbl(input logic [127:0] s);
        return s[127] ? ({s[126:0], 1'b0} ^ 128'h87) : {s[126:0], 1'b0};
    endfunction

endpackage

@@ rtl/core/block_cipher_cmac.sv @@
// After a setup step an accepted block goes through nine rounds of the round unit (key read,
// start, sixteen linear-layer steps, advance), then the final key and the output.
// One block is in work at a time, and the next is not taken until it is through; a MAC waiting
// in the output register holds off nothing until the next MAC is ready.
// After reset or a key write the first block also waits for key expansion (32 rounds) and
// one cipher pass for the subkeys. Reset: asynchronous, active low.
module block_cipher_cmac
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cmac_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cmac_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cmac_pkg::cfg_item_t  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_KX_RD, ST_KX_RUN, ST_KX_WR, ST_SK_START, ST_ENC_RD,
        ST_ENC_RUN, ST_ENC_NEXT, ST_SK_DONE, ST_MSG, ST_OUT
    } state_t;

    state_t        state_reg;
    logic [255:0]  key_reg;
    logic [4:0]    mac_bytes_reg;
    logic          keys_ready_reg;
    logic [127:0]  chain_reg;
    logic [127:0]  k1_reg;
    logic [127:0]  k2_reg;
    cmac_pkg::in_item_t item_reg;
    logic [127:0]  a1_reg;
    logic [127:0]  a0_reg;
    logic [127:0]  blk_reg;
    logic [5:0]    iter_reg;
    logic [3:0]    rnd_reg;
    logic          for_sk_reg;
    cmac_pkg::out_item_t out_reg;
    logic          out_valid_reg;

    // Round key memory, one 128-bit key per entry, registered read.
    logic [127:0]  rk_mem [cmac_pkg::RK_DEPTH];
    logic [127:0]  rk_rd;
    logic          rk_we;
    logic [3:0]    rk_waddr;
    logic [127:0]  rk_wdata;

    always_ff @(posedge clk)
    begin
        if (rk_we)
            rk_mem[rk_waddr] <= rk_wdata;
        rk_rd <= rk_mem[rnd_reg];
    end

    // Round unit.
    logic          rnd_start;
    logic [127:0]  rnd_state;
    logic [127:0]  rnd_key;
    logic          rnd_done;
    logic [127:0]  rnd_out;
    logic [127:0]  kx_const;

    cmac_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rnd_start),
        .state_in  (rnd_state),
        .key_in    (rnd_key),
        .done      (rnd_done),
        .state_out (rnd_out)
    );

    // Key expansion constant: L applied to the iteration number, built in
    // sixteen feedback steps as a round with zero sub-bytes bypass is not
    // available, so compute it through a small iterative unit below.
    logic [127:0]  c_work_reg;
    logic [4:0]    c_cnt_reg;
    assign kx_const = c_work_reg;

    logic          accept_in;
    logic [4:0]    nbytes;
    logic [127:0]  blk_in;
    logic [127:0]  pad_blk;
    logic [127:0]  keep_mask;
    logic [4:0]    mb;
    logic [127:0]  mac_mask;
    logic [127:0]  blk_reg_next_calc;
    logic          out_load;

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A finished MAC enters the output register once the previous one has left.
    assign out_load = (state_reg == ST_OUT) && item_reg.last_block
                      && (!out_valid_reg || !out_stall);

    // Block formatting (padding and subkey on the final block) and the MAC byte mask.
    always_comb
    begin
        nbytes = (item_reg.byte_count > 5'd16) ? 5'd16 : item_reg.byte_count;
        blk_in = {item_reg.block_high, item_reg.block_low};
        keep_mask = '0;
        pad_blk = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (5'(i) < nbytes)
                keep_mask[127 - 8*i -: 8] = 8'hFF;
            if (5'(i) == nbytes)
                pad_blk[127 - 8*i -: 8] = 8'h80;
        end
        if (!item_reg.last_block)
            blk_reg_next_calc = blk_in;
        else if (nbytes == 5'd16)
            blk_reg_next_calc = blk_in ^ k1_reg;
        else
            blk_reg_next_calc = ((blk_in & keep_mask) | pad_blk) ^ k2_reg;
        mb = (mac_bytes_reg > 5'd16) ? 5'd16 : mac_bytes_reg;
        mac_mask = '0;
        for (int i = 0; i < 16; i++)
            if (5'(i) < mb)
                mac_mask[127 - 8*i -: 8] = 8'hFF;
    end

    // Round unit operands.
    always_comb
    begin
        rnd_start = 1'b0;
        rnd_state = blk_reg;
        rnd_key   = rk_rd;
        if (state_reg == ST_KX_RUN && c_cnt_reg == 5'd16)
        begin
            rnd_start = 1'b1;
            rnd_state = a1_reg;
            rnd_key   = kx_const;
        end
        else if (state_reg == ST_ENC_RD)
            rnd_start = 1'b0;
        else if (state_reg == ST_ENC_RUN && iter_reg == 6'd0)
            rnd_start = 1'b1;
    end

    // Round key write port during expansion.
    always_comb
    begin
        rk_we    = 1'b0;
        rk_waddr = '0;
        rk_wdata = '0;
        if (state_reg == ST_KX_RD)
        begin
            rk_we    = 1'b1;
            rk_waddr = rnd_reg;
            rk_wdata = (rnd_reg == 4'd0) ? key_reg[255:128] : key_reg[127:0];
        end
        else if (state_reg == ST_KX_WR)
        begin
            rk_we    = 1'b1;
            rk_waddr = rnd_reg;
            rk_wdata = (rnd_reg[0] == 1'b0) ? a1_reg : a0_reg;
        end
    end

    // Main sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_reg        <= '0;
            mac_bytes_reg  <= 5'd8;
            keys_ready_reg <= 1'b0;
            chain_reg      <= '0;
            out_valid_reg  <= 1'b0;
            iter_reg       <= '0;
            rnd_reg        <= '0;
            c_cnt_reg      <= '0;
            for_sk_reg     <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_reg       <= blk_reg & mac_mask;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        item_reg <= in_data;
                        if (!keys_ready_reg)
                        begin
                            state_reg <= ST_KX_RD;
                            rnd_reg   <= '0;
                        end
                        else
                            state_reg <= ST_MSG;
                    end
                    else if (cfg_valid)
                    begin
                        case (cfg_data.index)
                            cmac_pkg::REG_KEY0:
                            begin
                                key_reg[255:192] <= cfg_data.data;
                                keys_ready_reg   <= 1'b0;
                            end
                            cmac_pkg::REG_KEY1:
                            begin
                                key_reg[191:128] <= cfg_data.data;
                                keys_ready_reg   <= 1'b0;
                            end
                            cmac_pkg::REG_KEY2:
                            begin
                                key_reg[127:64] <= cfg_data.data;
                                keys_ready_reg  <= 1'b0;
                            end
                            cmac_pkg::REG_KEY3:
                            begin
                                key_reg[63:0]  <= cfg_data.data;
                                keys_ready_reg <= 1'b0;
                            end
                            cmac_pkg::REG_MAC_BYTES:
                                mac_bytes_reg <= cfg_data.data[4:0];
                            default: ;
                        endcase
                    end
                end
                // Store the two key halves as round keys 0 and 1.
                ST_KX_RD:
                begin
                    a1_reg <= key_reg[255:128];
                    a0_reg <= key_reg[127:0];
                    if (rnd_reg == 4'd1)
                    begin
                        rnd_reg   <= 4'd2;
                        iter_reg  <= 6'd1;
                        c_cnt_reg <= '0;
                        c_work_reg <= '0;
                        state_reg <= ST_KX_RUN;
                    end
                    else
                        rnd_reg <= rnd_reg + 4'd1;
                end
                // Feistel step: build the constant, then one round.
                ST_KX_RUN:
                begin
                    if (c_cnt_reg == 5'd0)
                    begin
                        c_work_reg <= cmac_pkg::r_step({120'd0, 2'b00, iter_reg});
                        c_cnt_reg  <= 5'd1;
                    end
                    else if (c_cnt_reg < 5'd16)
                    begin
                        c_work_reg <= cmac_pkg::r_step(c_work_reg);
                        c_cnt_reg  <= c_cnt_reg + 5'd1;
                    end
                    else if (c_cnt_reg == 5'd16)
                    begin
                        c_work_reg <= cmac_pkg::r_step(c_work_reg);
                        c_cnt_reg  <= 5'd17;
                    end
                    else if (rnd_done)
                    begin
                        a1_reg    <= rnd_out ^ a0_reg;
                        a0_reg    <= a1_reg;
                        c_cnt_reg <= '0;
                        iter_reg  <= iter_reg + 6'd1;
                        if (iter_reg[2:0] == 3'd0)
                            state_reg <= ST_KX_WR;
                    end
                end
                // Two round keys after every eight steps.
                ST_KX_WR:
                begin
                    if (rnd_reg[0] == 1'b0)
                        rnd_reg <= rnd_reg + 4'd1;
                    else if (rnd_reg == 4'(cmac_pkg::RK_DEPTH - 1))
                        state_reg <= ST_SK_START;
                    else
                    begin
                        rnd_reg   <= rnd_reg + 4'd1;
                        state_reg <= ST_KX_RUN;
                    end
                end
                ST_SK_START:
                begin
                    blk_reg    <= '0;
                    for_sk_reg <= 1'b1;
                    rnd_reg    <= '0;
                    state_reg  <= ST_ENC_RD;
                end
                ST_MSG:
                begin
                    blk_reg    <= chain_reg ^ blk_reg_next_calc;
                    for_sk_reg <= 1'b0;
                    rnd_reg    <= '0;
                    state_reg  <= ST_ENC_RD;
                end
                // Wait for the registered round key read.
                ST_ENC_RD:
                begin
                    iter_reg  <= '0;
                    state_reg <= ST_ENC_RUN;
                end
                ST_ENC_RUN:
                begin
                    if (rnd_reg == 4'(cmac_pkg::CIPHER_ROUNDS - 1))
                    begin
                        blk_reg   <= blk_reg ^ rk_rd;
                        state_reg <= for_sk_reg ? ST_SK_DONE : ST_OUT;
                    end
                    else if (iter_reg == 6'd0)
                        iter_reg <= 6'd1;
                    else if (rnd_done)
                    begin
                        blk_reg   <= rnd_out;
                        rnd_reg   <= rnd_reg + 4'd1;
                        state_reg <= ST_ENC_NEXT;
                    end
                end
                ST_ENC_NEXT:
                    state_reg <= ST_ENC_RD;
                ST_SK_DONE:
                begin
                    k1_reg         <= cmac_pkg::dbl(blk_reg);
                    k2_reg         <= cmac_pkg::dbl(cmac_pkg::dbl(blk_reg));
                    keys_ready_reg <= 1'b1;
                    state_reg      <= ST_MSG;
                end
                // A MAC waits here only while the previous one is still held.
                ST_OUT:
                begin
                    if (item_reg.last_block)
                    begin
                        if (out_load)
                        begin
                            chain_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        chain_reg <= blk_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/cmac_round.sv @@
// Shared round unit: sub-bytes over state xor key, then the linear layer
// as sixteen feedback steps, one feedback step a cycle.
module cmac_round
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [127:0]   state_in,
    input  logic [127:0]   key_in,
    output logic           done,
    output logic [127:0]   state_out
);

    logic [127:0] work_reg;
    logic [4:0]   cnt_reg;
    logic         busy_reg;

    // Load the substituted value, then shift through the feedback.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            work_reg <= cmac_pkg::sub_bytes(state_in ^ key_in);
        else if (busy_reg)
            work_reg <= cmac_pkg::r_step(work_reg);
    end

    assign done      = busy_reg && (cnt_reg == 5'd15);
    assign state_out = cmac_pkg::r_step(work_reg);

endmodule

@@ rtl/core/cmac_checker.sv @@
`include "block_cipher_cmac_macros.svh"

// Port-level checks on the CMAC block.
module cmac_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input cmac_pkg::out_item_t out_data,
    input logic                cfg_valid,
    input logic                cfg_ready
);

    // A result held under stall keeps its value.
    `CMAC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, $stable(out_data), "out held")

    // An accepted transaction engages the block on the next cycle.
    `CMAC_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall && !cfg_valid, in_stall, "busy")

    // Configuration is only taken while no transaction is in work.
    `CMAC_ASSERT_IMPL(a_cfg_idle, clk, rst_n, cfg_ready, !in_stall, "cfg idle")

endmodule

bind block_cipher_cmac cmac_checker u_cmac_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
